// ===== hdl/cfie_pkg.sv =====
// Shared constants and types of the cuckoo filter insert engine.
package cfie_pkg;

    localparam int STORE_SLOTS_DEF     = 65536;
    localparam int MAX_SUB_FILTERS_DEF = 16;

    localparam int HASH_W   = 64;
    localparam int FP_W     = 8;
    localparam int BKT_W    = 17;
    localparam int ITEMS_W  = 17;
    localparam int FILTS_W  = 5;
    localparam int STATUS_W = 2;
    localparam int SLOTS_W  = 4;
    localparam int GROW_W   = 4;
    localparam int KICKS_W  = 10;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [31:0]      ALT_MULT   = 32'h5bd1e995;
    localparam logic [BKT_W-1:0] BKT_LIMIT  = 17'h1FFFF;
    localparam logic [ITEMS_W-1:0] CNT_LIMIT = 17'h1FFFF;

    localparam logic [BKT_W-1:0]   BASE_RST  = 17'd1024;
    localparam logic [SLOTS_W-1:0] SLOTS_RST = 4'd2;
    localparam logic [GROW_W-1:0]  GROW_RST  = 4'd1;
    localparam logic [KICKS_W-1:0] KICKS_RST = 10'd20;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_SLOTS = 2'd1;
    localparam logic [1:0] REG_GROW  = 2'd2;
    localparam logic [1:0] REG_KICKS = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_EXHAUSTED = 2'd2
    } t_status;

endpackage

// ===== hdl/cfie_in_if.sv =====
// Input channel: one item hash per beat.
interface cfie_in_if;
    logic                         valid;
    logic                         ready;
    logic [cfie_pkg::HASH_W-1:0]  item_hash;

    modport source (output valid, output item_hash, input ready);
    modport sink   (input valid, input item_hash, output ready);
endinterface

// ===== hdl/cfie_out_if.sv =====
// Output channel: one insert result per beat.
interface cfie_out_if;
    logic                          valid;
    logic                          ready;
    logic [cfie_pkg::STATUS_W-1:0] insert_status;
    logic [cfie_pkg::ITEMS_W-1:0]  stored_items;
    logic [cfie_pkg::FILTS_W-1:0]  active_filters;

    modport source (output valid, output insert_status, output stored_items,
                    output active_filters, input ready);
    modport sink   (input valid, input insert_status, input stored_items,
                    input active_filters, output ready);
endinterface

// ===== hdl/cfie_mod_unit.sv =====
// Bit-serial remainder unit: 64-bit dividend modulo a 17-bit bucket count.
module cfie_mod_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cfie_pkg::HASH_W-1:0]   i_dividend,
    input  logic [cfie_pkg::BKT_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [cfie_pkg::BKT_W-1:0]    o_rem
);
    localparam int STEP_W = $clog2(cfie_pkg::HASH_W);

    logic                          r_busy;
    logic                          r_done;
    logic [STEP_W-1:0]             r_step;
    logic [cfie_pkg::HASH_W-1:0]   r_num;
    logic [cfie_pkg::BKT_W-1:0]    r_den;
    logic [cfie_pkg::BKT_W-1:0]    r_rem;
    logic [cfie_pkg::BKT_W:0]      c_trial;
    logic [cfie_pkg::BKT_W:0]      c_diff;

    assign c_trial = {r_rem, r_num[cfie_pkg::HASH_W-1]};
    assign c_diff  = c_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_num  <= i_dividend;
                r_den  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[cfie_pkg::HASH_W-2:0], 1'b0};
                if (c_trial >= {1'b0, r_den}) begin
                    r_rem <= c_diff[cfie_pkg::BKT_W-1:0];
                end else begin
                    r_rem <= c_trial[cfie_pkg::BKT_W-1:0];
                end
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(cfie_pkg::HASH_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// ===== hdl/cuckoo_filter_insert_engine.sv =====
// Cuckoo filter insert engine: top level with fingerprint store and sequencer.
//
// One insert at a time. Every bucket index is hash modulo the sub-filter's bucket
// count, taken by a shared bit-serial remainder unit; each slot probe of the
// fingerprint store is a read and a check state. An insert that lands in the first
// slot of the newest sub-filter's first bucket runs the fingerprint, alternate-hash,
// round, filter, remainder, read, check and done states; the next beat is taken at
// the earliest in the cycle after its result is registered. Each further bucket adds
// a remainder and its probes, displacement starts with a remainder, a kick step is a
// swap, a remainder and its probes, an undo step a remainder and a swap, and a
// growth step the power, multiply, check and fit states. After reset and after any
// write of base_bucket_count or slots_per_bucket the store is cleared one slot a
// cycle with the input held off; the other registers are taken at any time. A new
// item is accepted while the previous result waits on the output.
module cuckoo_filter_insert_engine #(
    parameter int STORE_SLOTS     = cfie_pkg::STORE_SLOTS_DEF,
    parameter int MAX_SUB_FILTERS = cfie_pkg::MAX_SUB_FILTERS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cfie_in_if.sink                     i_in,
    cfie_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfie_pkg::APB_AW-1:0] paddr,
    input  logic [cfie_pkg::APB_DW-1:0] pwdata,
    output logic [cfie_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    localparam int AW     = $clog2(STORE_SLOTS);
    localparam int BW     = AW + 1;
    localparam int SUM_W  = ((BW > 21) ? BW : 21) + 1;
    localparam int GW     = AW + 2;
    localparam int NBW    = cfie_pkg::BKT_W + GW;
    localparam int KW     = (MAX_SUB_FILTERS > 1) ? $clog2(MAX_SUB_FILTERS) : 1;
    localparam int FW     = $clog2(MAX_SUB_FILTERS + 1);
    localparam int RW     = $clog2(MAX_SUB_FILTERS + 2);
    localparam int CMP_W  = (BW > cfie_pkg::BKT_W) ? BW : cfie_pkg::BKT_W;
    localparam int BKT_W  = cfie_pkg::BKT_W;
    localparam int FP_W   = cfie_pkg::FP_W;
    localparam int HASH_W = cfie_pkg::HASH_W;

    typedef enum logic [4:0] {
        S_IDLE, S_FP, S_H2, S_ROUND, S_FILT, S_SDIV, S_SRD, S_SCHK, S_NEXTK,
        S_KICK, S_KDIV0, S_KLOOP, S_KSWAP, S_KALT, S_KADIV, S_KRD, S_KCHK,
        S_RB, S_RDIV, S_RRD, S_RSWAP, S_FAIL, S_GPOW, S_GMUL, S_GCHK, S_GFIT,
        S_DONE
    } t_state;

    t_state                         r_state;
    logic [BKT_W-1:0]               r_cfg_base;
    logic [cfie_pkg::SLOTS_W-1:0]   r_cfg_slots;
    logic [cfie_pkg::GROW_W-1:0]    r_cfg_grow;
    logic [cfie_pkg::KICKS_W-1:0]   r_cfg_kicks;

    logic                           r_clr;
    logic [AW-1:0]                  r_caddr;
    logic [FP_W-1:0]                r_mem [STORE_SLOTS];
    logic [FP_W-1:0]                r_rdata;

    logic [BW-1:0]                  r_fbase [MAX_SUB_FILTERS];
    logic [BKT_W-1:0]               r_fbkt  [MAX_SUB_FILTERS];
    logic [FW-1:0]                  r_ft;
    logic [cfie_pkg::ITEMS_W-1:0]   r_items;

    logic [HASH_W-1:0]              r_hash;
    logic [HASH_W-1:0]              r_h2;
    logic [FP_W-1:0]                r_fp;
    logic [FP_W-1:0]                r_cfp;
    logic [KW-1:0]                  r_k;
    logic                           r_sel;
    logic [2:0]                     r_j;
    logic [2:0]                     r_victim;
    logic [BW-1:0]                  r_baddr;
    logic [BKT_W-1:0]               r_ii;
    logic [cfie_pkg::KICKS_W-1:0]   r_cnt;
    logic [RW-1:0]                  r_round;
    logic [FW-1:0]                  r_gi;
    logic [GW-1:0]                  r_g;
    logic [NBW-1:0]                 r_nb;
    logic [SUM_W-1:0]               r_gbase;
    logic [SUM_W-1:0]               r_need;
    cfie_pkg::t_status              r_status;

    logic                           r_div_start;
    logic [HASH_W-1:0]              r_div_in;
    logic [BKT_W-1:0]               r_div_den;
    logic                           div_done;
    logic [BKT_W-1:0]               div_rem;

    logic                           r_out_valid;
    cfie_pkg::t_status              r_out_status;
    logic [cfie_pkg::ITEMS_W-1:0]   r_out_items;
    logic [cfie_pkg::FILTS_W-1:0]   r_out_filts;

    logic                           cfg_wr;
    logic [3:0]                     s_eff;
    logic [cfie_pkg::GROW_W-1:0]    gf_eff;
    logic [BKT_W-1:0]               b0;
    logic [BKT_W-1:0]               c_nb;
    logic [BW-1:0]                  c_base;
    logic [FW-1:0]                  c_ftm1;
    logic [2:0]                     c_slast;
    logic [BW-1:0]                  slot_addr;
    logic [BW-1:0]                  kick_addr;
    logic [BW-1:0]                  c_bkt_addr;
    logic [FP_W-1:0]                c_fp;
    logic [GW+cfie_pkg::GROW_W-1:0] c_gprod;
    logic [SUM_W:0]                 c_gend;
    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [FP_W-1:0]                mem_wdata;
    logic [AW-1:0]                  mem_raddr;
    logic                           slot_empty;

    function automatic logic [FP_W-1:0] f_fingerprint(input logic [HASH_W-1:0] h);
        logic [10:0] sum;
        logic [8:0]  fold;
        logic [8:0]  red;
        sum = '0;
        for (int b = 0; b < 8; b++) begin
            sum = sum + 11'(h[8*b +: 8]);
        end
        fold = 9'(sum[10:8]) + 9'(sum[7:0]);
        red  = (fold >= 9'd255) ? fold - 9'd255 : fold;
        return red[7:0] + 8'd1;
    endfunction

    function automatic logic [BKT_W-1:0] f_base_eff(input logic [BKT_W-1:0] raw,
                                                     input logic [3:0] s);
        logic [CMP_W-1:0] cap;
        logic [CMP_W-1:0] b;
        unique case (s)
            4'd1:    cap = CMP_W'(STORE_SLOTS / 1);
            4'd2:    cap = CMP_W'(STORE_SLOTS / 2);
            4'd3:    cap = CMP_W'(STORE_SLOTS / 3);
            4'd4:    cap = CMP_W'(STORE_SLOTS / 4);
            4'd5:    cap = CMP_W'(STORE_SLOTS / 5);
            4'd6:    cap = CMP_W'(STORE_SLOTS / 6);
            4'd7:    cap = CMP_W'(STORE_SLOTS / 7);
            default: cap = CMP_W'(STORE_SLOTS / 8);
        endcase
        b = (raw == '0) ? CMP_W'(1) : CMP_W'(raw);
        if (b > cap) b = cap;
        return b[BKT_W-1:0];
    endfunction

    function automatic logic [HASH_W-1:0] f_alt(input logic [FP_W-1:0] fp,
                                                 input logic [HASH_W-1:0] idx);
        return idx ^ HASH_W'(40'(fp) * 40'(cfie_pkg::ALT_MULT));
    endfunction

    assign s_eff   = (r_cfg_slots == '0) ? 4'd1 : ((r_cfg_slots > 4'd8) ? 4'd8 : r_cfg_slots);
    assign gf_eff  = (r_cfg_grow > 4'd8) ? 4'd8 : r_cfg_grow;
    assign b0      = f_base_eff(r_cfg_base, s_eff);
    assign c_nb    = (r_k == '0) ? b0 : r_fbkt[r_k];
    assign c_base  = (r_k == '0) ? '0 : r_fbase[r_k];
    assign c_ftm1  = r_ft - FW'(1);
    assign c_slast = 3'(s_eff - 4'd1);
    assign c_fp    = f_fingerprint(r_hash);
    assign c_gprod = r_g * gf_eff;
    assign c_gend  = {1'b0, r_gbase} + (SUM_W+1)'(r_need);

    assign slot_addr  = r_baddr + BW'(r_j);
    assign kick_addr  = BW'(SUM_W'(c_base) + SUM_W'(r_ii) * SUM_W'(s_eff)
                            + SUM_W'(r_victim));
    assign c_bkt_addr = BW'(SUM_W'(c_base) + SUM_W'(div_rem) * SUM_W'(s_eff));
    assign slot_empty = (r_rdata == '0);

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            cfie_pkg::REG_BASE:  prdata = 32'(r_cfg_base);
            cfie_pkg::REG_SLOTS: prdata = 32'(r_cfg_slots);
            cfie_pkg::REG_GROW:  prdata = 32'(r_cfg_grow);
            default:             prdata = 32'(r_cfg_kicks);
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = kick_addr[AW-1:0];
        mem_wdata = r_cfp;
        if (r_clr) begin
            mem_we    = 1'b1;
            mem_waddr = r_caddr;
            mem_wdata = '0;
        end else begin
            priority case (r_state)
                S_SCHK: begin
                    mem_we    = slot_empty;
                    mem_waddr = slot_addr[AW-1:0];
                    mem_wdata = r_fp;
                end
                S_KCHK: begin
                    mem_we    = slot_empty;
                    mem_waddr = slot_addr[AW-1:0];
                end
                S_KSWAP, S_RSWAP: mem_we = 1'b1;
                default: mem_we = 1'b0;
            endcase
        end
        mem_raddr = (r_state == S_SRD || r_state == S_KRD) ? slot_addr[AW-1:0]
                                                          : kick_addr[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    cfie_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_in),
        .i_divisor  (r_div_den),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign i_in.ready          = (r_state == S_IDLE) && !r_clr;
    assign o_out.valid         = r_out_valid;
    assign o_out.insert_status = r_out_status;
    assign o_out.stored_items  = r_out_items;
    assign o_out.active_filters = r_out_filts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_base  <= cfie_pkg::BASE_RST;
            r_cfg_slots <= cfie_pkg::SLOTS_RST;
            r_cfg_grow  <= cfie_pkg::GROW_RST;
            r_cfg_kicks <= cfie_pkg::KICKS_RST;
            r_clr       <= 1'b1;
            r_caddr     <= '0;
            r_ft        <= FW'(1);
            r_items     <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_clr) begin
                r_caddr <= r_caddr + AW'(1);
                if (r_caddr == AW'(STORE_SLOTS - 1)) begin
                    r_clr <= 1'b0;
                end
            end

            if (cfg_wr) begin
                unique case (paddr[3:2])
                    cfie_pkg::REG_BASE: begin
                        r_cfg_base <= pwdata[BKT_W-1:0];
                    end
                    cfie_pkg::REG_SLOTS: begin
                        r_cfg_slots <= pwdata[cfie_pkg::SLOTS_W-1:0];
                    end
                    cfie_pkg::REG_GROW: begin
                        r_cfg_grow <= pwdata[cfie_pkg::GROW_W-1:0];
                    end
                    default: begin
                        r_cfg_kicks <= pwdata[cfie_pkg::KICKS_W-1:0];
                    end
                endcase
                if (paddr[3:2] == cfie_pkg::REG_BASE || paddr[3:2] == cfie_pkg::REG_SLOTS) begin
                    r_clr   <= 1'b1;
                    r_caddr <= '0;
                    r_ft    <= FW'(1);
                    r_items <= '0;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_hash  <= i_in.item_hash;
                        r_state <= S_FP;
                    end
                end
                S_FP: begin
                    r_fp    <= c_fp;
                    r_state <= S_H2;
                end
                S_H2: begin
                    r_h2    <= f_alt(r_fp, r_hash);
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_k     <= c_ftm1[KW-1:0];
                    r_state <= S_FILT;
                end
                S_FILT: begin
                    if (c_nb == '0) begin
                        r_state <= S_NEXTK;
                    end else begin
                        r_sel       <= 1'b0;
                        r_div_start <= 1'b1;
                        r_div_in    <= r_hash;
                        r_div_den   <= c_nb;
                        r_state     <= S_SDIV;
                    end
                end
                S_SDIV: begin
                    if (div_done) begin
                        r_baddr <= c_bkt_addr;
                        r_j     <= '0;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: r_state <= S_SCHK;
                S_SCHK: begin
                    if (slot_empty) begin
                        if (r_items < cfie_pkg::CNT_LIMIT) r_items <= r_items + 17'd1;
                        r_status <= cfie_pkg::ST_INSERTED;
                        r_state  <= S_DONE;
                    end else if (r_j == c_slast) begin
                        if (!r_sel) begin
                            r_sel       <= 1'b1;
                            r_div_start <= 1'b1;
                            r_div_in    <= r_h2;
                            r_div_den   <= c_nb;
                            r_state     <= S_SDIV;
                        end else begin
                            r_state <= S_NEXTK;
                        end
                    end else begin
                        r_j     <= r_j + 3'd1;
                        r_state <= S_SRD;
                    end
                end
                S_NEXTK: begin
                    if (r_k == '0) begin
                        r_k     <= c_ftm1[KW-1:0];
                        r_state <= S_KICK;
                    end else begin
                        r_k     <= r_k - KW'(1);
                        r_state <= S_FILT;
                    end
                end
                S_KICK: begin
                    if (c_nb == '0) begin
                        r_state <= S_FAIL;
                    end else begin
                        r_div_start <= 1'b1;
                        r_div_in    <= r_hash;
                        r_div_den   <= c_nb;
                        r_victim    <= '0;
                        r_cnt       <= '0;
                        r_cfp       <= r_fp;
                        r_state     <= S_KDIV0;
                    end
                end
                S_KDIV0: begin
                    if (div_done) begin
                        r_ii    <= div_rem;
                        r_state <= S_KLOOP;
                    end
                end
                S_KLOOP: begin
                    if (r_cnt == r_cfg_kicks) begin
                        r_cnt   <= '0;
                        r_state <= S_RB;
                    end else begin
                        r_state <= S_KSWAP;
                    end
                end
                S_KSWAP: begin
                    r_cfp   <= r_rdata;
                    r_state <= S_KALT;
                end
                S_KALT: begin
                    r_div_start <= 1'b1;
                    r_div_in    <= f_alt(r_cfp, HASH_W'(r_ii));
                    r_div_den   <= c_nb;
                    r_state     <= S_KADIV;
                end
                S_KADIV: begin
                    if (div_done) begin
                        r_ii    <= div_rem;
                        r_baddr <= c_bkt_addr;
                        r_j     <= '0;
                        r_state <= S_KRD;
                    end
                end
                S_KRD: r_state <= S_KCHK;
                S_KCHK: begin
                    if (slot_empty) begin
                        if (r_items < cfie_pkg::CNT_LIMIT) r_items <= r_items + 17'd1;
                        r_status <= cfie_pkg::ST_INSERTED;
                        r_state  <= S_DONE;
                    end else if (r_j == c_slast) begin
                        r_victim <= (r_victim == c_slast) ? 3'd0 : r_victim + 3'd1;
                        r_cnt    <= r_cnt + 10'd1;
                        r_state  <= S_KLOOP;
                    end else begin
                        r_j     <= r_j + 3'd1;
                        r_state <= S_KRD;
                    end
                end
                S_RB: begin
                    if (r_cnt == r_cfg_kicks) begin
                        r_state <= S_FAIL;
                    end else begin
                        r_victim    <= (r_victim == 3'd0) ? c_slast : r_victim - 3'd1;
                        r_div_start <= 1'b1;
                        r_div_in    <= f_alt(r_cfp, HASH_W'(r_ii));
                        r_div_den   <= c_nb;
                        r_state     <= S_RDIV;
                    end
                end
                S_RDIV: begin
                    if (div_done) begin
                        r_ii    <= div_rem;
                        r_state <= S_RRD;
                    end
                end
                S_RRD: r_state <= S_RSWAP;
                S_RSWAP: begin
                    r_cfp   <= r_rdata;
                    r_cnt   <= r_cnt + 10'd1;
                    r_state <= S_RB;
                end
                S_FAIL: begin
                    r_k <= c_ftm1[KW-1:0];
                    if (r_cfg_grow == '0) begin
                        r_status <= cfie_pkg::ST_NO_SPACE;
                        r_state  <= S_DONE;
                    end else if (r_ft >= FW'(MAX_SUB_FILTERS)) begin
                        r_status <= cfie_pkg::ST_EXHAUSTED;
                        r_state  <= S_DONE;
                    end else begin
                        r_g     <= GW'(1);
                        r_gi    <= '0;
                        r_state <= S_GPOW;
                    end
                end
                S_GPOW: begin
                    if (r_gi == r_ft) begin
                        r_state <= S_GMUL;
                    end else begin
                        r_g  <= (c_gprod > (GW+cfie_pkg::GROW_W)'(STORE_SLOTS))
                              ? GW'(STORE_SLOTS + 1) : c_gprod[GW-1:0];
                        r_gi <= r_gi + FW'(1);
                    end
                end
                S_GMUL: begin
                    r_nb    <= b0 * r_g;
                    r_state <= S_GCHK;
                end
                S_GCHK: begin
                    if (r_nb == '0 || r_nb > NBW'(cfie_pkg::BKT_LIMIT)) begin
                        r_status <= cfie_pkg::ST_EXHAUSTED;
                        r_state  <= S_DONE;
                    end else begin
                        r_gbase <= SUM_W'(c_base) + SUM_W'(c_nb) * SUM_W'(s_eff);
                        r_need  <= SUM_W'(r_nb[BKT_W-1:0]) * SUM_W'(s_eff);
                        r_state <= S_GFIT;
                    end
                end
                S_GFIT: begin
                    if (c_gend > (SUM_W+1)'(STORE_SLOTS)) begin
                        r_status <= cfie_pkg::ST_EXHAUSTED;
                        r_state  <= S_DONE;
                    end else begin
                        r_fbase[r_ft[KW-1:0]] <= r_gbase[BW-1:0];
                        r_fbkt[r_ft[KW-1:0]]  <= r_nb[BKT_W-1:0];
                        r_ft                  <= r_ft + FW'(1);
                        if (r_round == RW'(MAX_SUB_FILTERS)) begin
                            r_status <= cfie_pkg::ST_NO_SPACE;
                            r_state  <= S_DONE;
                        end else begin
                            r_round <= r_round + RW'(1);
                            r_state <= S_ROUND;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_items  <= r_items;
                        r_out_filts  <= cfie_pkg::FILTS_W'(r_ft);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/cfie_checker.sv =====
// Port-level checks of the insert engine and their binding to the top level.
module cfie_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [cfie_pkg::STATUS_W-1:0] i_out_status,
    input logic [cfie_pkg::ITEMS_W-1:0]  i_out_items,
    input logic [cfie_pkg::FILTS_W-1:0]  i_out_filts
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
            && $stable(i_out_items) && $stable(i_out_filts))
        else $error("output beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again before the insert finished");

    a_filters_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_filts != '0)
        else $error("result reports no sub-filter");
endmodule

bind cuckoo_filter_insert_engine cfie_checker u_cfie_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.insert_status),
    .i_out_items  (o_out.stored_items),
    .i_out_filts  (o_out.active_filters)
);
